// ===== design/tppw_pkg.sv =====
// Shared types, widths and constants for the three-phase line real power block.
// No dependencies; every other design file but tppw_divider imports this package.
package tppw_pkg;

    // Field widths of the words on the ports
    localparam int R_W   = 24;
    localparam int V_W   = 20;
    localparam int ANG_W = 16;
    localparam int POW_W = 40;

    // CORDIC datapath
    localparam int ATAN_ENTRIES = 24;
    localparam int XY_W         = 33;
    localparam int Z_W          = 34;
    localparam int ANG_SHIFT    = 17;
    localparam int TRIG_SHIFT   = 14;
    localparam int TRIG_W       = XY_W - TRIG_SHIFT;
    localparam int ROUND_Q16    = 8192;

    localparam logic signed [XY_W-1:0] KINV_Q30    = 33'sd652032874;
    localparam logic signed [Z_W-1:0]  HALF_PI_Q30 = 34'sd1686629713;
    localparam logic signed [Z_W-1:0]  PI_Q30      = 34'sd3373259426;

    // Phase arithmetic
    localparam int PROD_W = V_W + 1 + TRIG_W;
    localparam int DIFF_W = PROD_W + 1;
    localparam int T_W    = 64;
    localparam int MAG_W  = T_W - 1;
    localparam int LO_W   = 32;
    localparam int PLO_W  = V_W + LO_W;
    localparam int PHI_W  = V_W + MAG_W - LO_W;
    localparam int D_W    = 2 * R_W + 1;
    localparam int DEN_W  = D_W + 10;
    localparam int NUM_W  = PHI_W + LO_W + 1;
    localparam int PW_W   = NUM_W + 1;
    localparam int SUM_W  = PW_W + 2;

    localparam logic signed [POW_W-1:0] POW_MAX = {1'b0, {(POW_W-1){1'b1}}};
    localparam logic signed [POW_W-1:0] POW_MIN = {1'b1, {(POW_W-1){1'b0}}};

    // Operands that travel with one phase through the CORDIC and multipliers
    typedef struct packed {
        logic [R_W-1:0]   r;
        logic [R_W-1:0]   x;
        logic [V_W-1:0]   vu;
        logic [V_W-1:0]   vv;
        logic [DEN_W-1:0] den;
        logic             zero;
    } phase_side_t;

    // One result word
    typedef struct packed {
        logic signed [POW_W-1:0] line_power;
        logic                    zero_impedance;
        logic                    saturated;
    } result_t;

    // atan(2^-i) in Q30
    function automatic logic [30:0] atan_q30(input logic [4:0] idx);
        logic [30:0] v;
        case (idx)
            5'd0:    v = 31'd843314857;
            5'd1:    v = 31'd497837829;
            5'd2:    v = 31'd263043837;
            5'd3:    v = 31'd133525159;
            5'd4:    v = 31'd67021687;
            5'd5:    v = 31'd33543516;
            5'd6:    v = 31'd16775851;
            5'd7:    v = 31'd8388437;
            5'd8:    v = 31'd4194283;
            5'd9:    v = 31'd2097149;
            5'd10:   v = 31'd1048576;
            5'd11:   v = 31'd524288;
            5'd12:   v = 31'd262144;
            5'd13:   v = 31'd131072;
            5'd14:   v = 31'd65536;
            5'd15:   v = 31'd32768;
            5'd16:   v = 31'd16384;
            5'd17:   v = 31'd8192;
            5'd18:   v = 31'd4096;
            5'd19:   v = 31'd2048;
            5'd20:   v = 31'd1024;
            5'd21:   v = 31'd512;
            5'd22:   v = 31'd256;
            5'd23:   v = 31'd128;
            default: v = 31'd0;
        endcase
        return v;
    endfunction

endpackage

// ===== design/tppw_in_if.sv =====
// Input channel: one line's impedance, voltages and angles per word.
// Depends on tppw_pkg.
interface tppw_in_if;
    import tppw_pkg::*;

    logic                    valid;
    logic                    ready;
    logic [R_W-1:0]          resistance;
    logic [R_W-1:0]          reactance;
    logic [V_W-1:0]          from_voltage_a;
    logic [V_W-1:0]          from_voltage_b;
    logic [V_W-1:0]          from_voltage_c;
    logic [V_W-1:0]          to_voltage_a;
    logic [V_W-1:0]          to_voltage_b;
    logic [V_W-1:0]          to_voltage_c;
    logic signed [ANG_W-1:0] angle_diff_a;
    logic signed [ANG_W-1:0] angle_diff_b;
    logic signed [ANG_W-1:0] angle_diff_c;

    modport source (
        output valid, resistance, reactance,
        output from_voltage_a, from_voltage_b, from_voltage_c,
        output to_voltage_a, to_voltage_b, to_voltage_c,
        output angle_diff_a, angle_diff_b, angle_diff_c,
        input  ready
    );

    modport sink (
        input  valid, resistance, reactance,
        input  from_voltage_a, from_voltage_b, from_voltage_c,
        input  to_voltage_a, to_voltage_b, to_voltage_c,
        input  angle_diff_a, angle_diff_b, angle_diff_c,
        output ready
    );
endinterface

// ===== design/tppw_out_if.sv =====
// Output channel: three-phase real power and status flags per word.
// Depends on tppw_pkg.
interface tppw_out_if;
    import tppw_pkg::*;

    logic                    valid;
    logic                    ready;
    logic signed [POW_W-1:0] line_power;
    logic                    zero_impedance;
    logic                    saturated;

    modport source (
        output valid, line_power, zero_impedance, saturated,
        input  ready
    );

    modport sink (
        input  valid, line_power, zero_impedance, saturated,
        output ready
    );
endinterface

// ===== design/tppw_cordic.sv =====
// Pipelined rotation-mode CORDIC: Q3.13 angle in, Q16 cosine and sine out.
// One register stage per iteration plus entry and rounding stages. Depends on tppw_pkg.
module tppw_cordic #(
    parameter int STEPS = 16,
    parameter int TAG_W = 1
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                en,
    input  logic                                in_valid,
    input  logic signed [tppw_pkg::ANG_W-1:0]   ang,
    input  logic [TAG_W-1:0]                    tag_in,
    output logic                                out_valid,
    output logic signed [tppw_pkg::TRIG_W-1:0]  cos_q16,
    output logic signed [tppw_pkg::TRIG_W-1:0]  sin_q16,
    output logic [TAG_W-1:0]                    tag_out
);
    import tppw_pkg::*;

    logic signed [XY_W-1:0]   x_reg [0:STEPS];
    logic signed [XY_W-1:0]   y_reg [0:STEPS];
    logic signed [Z_W-1:0]    z_reg [0:STEPS];
    logic [STEPS:0]           flip_reg;
    logic [TAG_W-1:0]         tag_reg [0:STEPS];
    logic [STEPS+1:0]         vld_reg;

    logic signed [Z_W-1:0]    z_raw;
    logic signed [Z_W-1:0]    z0_next;
    logic                     flip0_next;
    logic signed [XY_W-1:0]   xf;
    logic signed [XY_W-1:0]   yf;
    logic signed [TRIG_W-1:0] cos_next;
    logic signed [TRIG_W-1:0] sin_next;
    logic signed [TRIG_W-1:0] cos_reg;
    logic signed [TRIG_W-1:0] sin_reg;
    logic [TAG_W-1:0]         tag_out_reg;

    // Scale angle to Q30 and fold it into [-pi/2, pi/2]
    assign z_raw = {{(Z_W-ANG_W-ANG_SHIFT){ang[ANG_W-1]}}, ang, {ANG_SHIFT{1'b0}}};

    always_comb
    begin
        z0_next    = z_raw;
        flip0_next = 1'b0;
        if (z_raw > HALF_PI_Q30)
        begin
            z0_next    = z_raw - PI_Q30;
            flip0_next = 1'b1;
        end
        else if (z_raw < -HALF_PI_Q30)
        begin
            z0_next    = z_raw + PI_Q30;
            flip0_next = 1'b1;
        end
    end

    // Undo the fold and round to Q16
    always_comb
    begin
        xf       = flip_reg[STEPS] ? -x_reg[STEPS] : x_reg[STEPS];
        yf       = flip_reg[STEPS] ? -y_reg[STEPS] : y_reg[STEPS];
        cos_next = TRIG_W'((xf + XY_W'(ROUND_Q16)) >>> TRIG_SHIFT);
        sin_next = TRIG_W'((yf + XY_W'(ROUND_Q16)) >>> TRIG_SHIFT);
    end

    // Advance valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[STEPS:0], in_valid};
        end
    end

    // Advance the rotation stages
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg[0]    <= KINV_Q30;
            y_reg[0]    <= '0;
            z_reg[0]    <= z0_next;
            flip_reg[0] <= flip0_next;
            tag_reg[0]  <= tag_in;
            for (int i = 0; i < STEPS; i++)
            begin
                if (!z_reg[i][Z_W-1])
                begin
                    x_reg[i+1] <= x_reg[i] - (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] + (x_reg[i] >>> i);
                    z_reg[i+1] <= z_reg[i] - $signed({3'b000, atan_q30(5'(i))});
                end
                else
                begin
                    x_reg[i+1] <= x_reg[i] + (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] - (x_reg[i] >>> i);
                    z_reg[i+1] <= z_reg[i] + $signed({3'b000, atan_q30(5'(i))});
                end
                flip_reg[i+1] <= flip_reg[i];
                tag_reg[i+1]  <= tag_reg[i];
            end
            cos_reg     <= cos_next;
            sin_reg     <= sin_next;
            tag_out_reg <= tag_reg[STEPS];
        end
    end

    assign out_valid = vld_reg[STEPS+1];
    assign cos_q16   = cos_reg;
    assign sin_q16   = sin_reg;
    assign tag_out   = tag_out_reg;

endmodule

// ===== design/tppw_divider.sv =====
// Pipelined restoring divider, one quotient bit per register stage.
// Carries the divisor and a side tag with each word. Depends on nothing.
module tppw_divider #(
    parameter int NUM_W = 84,
    parameter int DEN_W = 59,
    parameter int TAG_W = 2
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               en,
    input  logic               in_valid,
    input  logic [NUM_W-1:0]   num,
    input  logic [DEN_W-1:0]   den,
    input  logic [TAG_W-1:0]   tag_in,
    output logic               out_valid,
    output logic [NUM_W-1:0]   quotient,
    output logic [TAG_W-1:0]   tag_out
);

    logic [DEN_W-1:0] rem_reg [0:NUM_W-1];
    logic [NUM_W-1:0] quo_reg [0:NUM_W-1];
    logic [DEN_W-1:0] den_reg [0:NUM_W-1];
    logic [TAG_W-1:0] tag_reg [0:NUM_W-1];
    logic [NUM_W-1:0] vld_reg;

    logic [DEN_W-1:0] src_rem [0:NUM_W-1];
    logic [NUM_W-1:0] src_quo [0:NUM_W-1];
    logic [DEN_W-1:0] src_den [0:NUM_W-1];
    logic [TAG_W-1:0] src_tag [0:NUM_W-1];
    logic [DEN_W:0]   shifted [0:NUM_W-1];
    logic [NUM_W-1:0] ge;
    logic [DEN_W-1:0] rem_next [0:NUM_W-1];
    logic [NUM_W-1:0] quo_next [0:NUM_W-1];

    // Feed each stage from the one before it
    assign src_rem[0] = '0;
    assign src_quo[0] = num;
    assign src_den[0] = den;
    assign src_tag[0] = tag_in;

    for (genvar k = 1; k < NUM_W; k++)
    begin : g_src
        assign src_rem[k] = rem_reg[k-1];
        assign src_quo[k] = quo_reg[k-1];
        assign src_den[k] = den_reg[k-1];
        assign src_tag[k] = tag_reg[k-1];
    end

    // Shift in one dividend bit, compare, subtract
    always_comb
    begin
        for (int k = 0; k < NUM_W; k++)
        begin
            shifted[k]  = {src_rem[k], src_quo[k][NUM_W-1]};
            ge[k]       = shifted[k] >= {1'b0, src_den[k]};
            rem_next[k] = ge[k] ? DEN_W'(shifted[k] - {1'b0, src_den[k]})
                                : DEN_W'(shifted[k]);
            quo_next[k] = {src_quo[k][NUM_W-2:0], ge[k]};
        end
    end

    // Advance valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[NUM_W-2:0], in_valid};
        end
    end

    // Advance remainders, partial quotients and side data
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < NUM_W; k++)
            begin
                rem_reg[k] <= rem_next[k];
                quo_reg[k] <= quo_next[k];
                den_reg[k] <= src_den[k];
                tag_reg[k] <= src_tag[k];
            end
        end
    end

    assign out_valid = vld_reg[NUM_W-1];
    assign quotient  = quo_reg[NUM_W-1];
    assign tag_out   = tag_reg[NUM_W-1];

endmodule

// ===== design/tppw_phase.sv =====
// One phase's real power term: CORDIC, product stages and rounded division.
// Depends on tppw_pkg, tppw_cordic and tppw_divider.
module tppw_phase #(
    parameter int STEPS = 16
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              en,
    input  logic                              in_valid,
    input  tppw_pkg::phase_side_t             side_in,
    input  logic signed [tppw_pkg::ANG_W-1:0] ang,
    output logic                              out_valid,
    output logic signed [tppw_pkg::PW_W-1:0]  power,
    output logic                              zero_out
);
    import tppw_pkg::*;

    logic                     c_valid;
    logic signed [TRIG_W-1:0] cos_q16;
    logic signed [TRIG_W-1:0] sin_q16;
    phase_side_t              side_c;

    logic [4:0]               vld_reg;
    phase_side_t              side1_reg;
    phase_side_t              side2_reg;
    phase_side_t              side3_reg;
    phase_side_t              side4_reg;
    phase_side_t              side5_reg;

    logic signed [PROD_W-1:0] prod_c;
    logic signed [DIFF_W-1:0] diff_next;
    logic signed [DIFF_W-1:0] diff_reg;
    logic signed [PROD_W-1:0] vs_next;
    logic signed [PROD_W-1:0] vs_reg;
    logic signed [T_W-1:0]    pr_next;
    logic signed [T_W-1:0]    px_next;
    logic signed [T_W-1:0]    pr_reg;
    logic signed [T_W-1:0]    px_reg;
    logic signed [T_W-1:0]    t_sum;
    logic signed [T_W-1:0]    t_abs;
    logic [MAG_W-1:0]         mag_reg;
    logic                     neg3_reg;
    logic                     neg4_reg;
    logic                     neg5_reg;
    logic [PLO_W-1:0]         plo_reg;
    logic [PHI_W-1:0]         phi_reg;
    logic [NUM_W-1:0]         num_next;
    logic [NUM_W-1:0]         num_reg;

    logic                     d_valid;
    logic [NUM_W-1:0]         quotient;
    logic [1:0]               d_tag;
    logic signed [PW_W-1:0]   q_signed;
    logic signed [PW_W-1:0]   power_reg;
    logic                     zero_reg;
    logic                     pw_vld_reg;

    tppw_cordic #(
        .STEPS (STEPS),
        .TAG_W ($bits(phase_side_t))
    ) u_cordic (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (in_valid),
        .ang       (ang),
        .tag_in    (side_in),
        .out_valid (c_valid),
        .cos_q16   (cos_q16),
        .sin_q16   (sin_q16),
        .tag_out   (side_c)
    );

    // Voltage difference term and receiving-end sine product
    always_comb
    begin
        prod_c    = $signed({1'b0, side_c.vv}) * cos_q16;
        diff_next = DIFF_W'($signed({1'b0, side_c.vu, 16'd0})) - DIFF_W'(prod_c);
        vs_next   = $signed({1'b0, side_c.vv}) * sin_q16;
    end

    // Impedance products, sum and magnitude
    always_comb
    begin
        pr_next = $signed({1'b0, side1_reg.r}) * diff_reg;
        px_next = $signed({1'b0, side1_reg.x}) * vs_reg;
        t_sum   = pr_reg + px_reg;
        t_abs   = t_sum[T_W-1] ? -t_sum : t_sum;
    end

    // Join the partial products and add half the divisor for rounding
    assign num_next = NUM_W'(plo_reg) + NUM_W'({phi_reg, {LO_W{1'b0}}})
                    + NUM_W'(side4_reg.den >> 1);

    // Advance valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg    <= '0;
            pw_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            vld_reg    <= {vld_reg[3:0], c_valid};
            pw_vld_reg <= d_valid;
        end
    end

    // Advance the product stages
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            diff_reg  <= diff_next;
            vs_reg    <= vs_next;
            side1_reg <= side_c;
            pr_reg    <= pr_next;
            px_reg    <= px_next;
            side2_reg <= side1_reg;
            mag_reg   <= t_abs[MAG_W-1:0];
            neg3_reg  <= t_sum[T_W-1];
            side3_reg <= side2_reg;
            plo_reg   <= side3_reg.vu * mag_reg[LO_W-1:0];
            phi_reg   <= side3_reg.vu * mag_reg[MAG_W-1:LO_W];
            neg4_reg  <= neg3_reg;
            side4_reg <= side3_reg;
            num_reg   <= num_next;
            neg5_reg  <= neg4_reg;
            side5_reg <= side4_reg;
            power_reg <= q_signed;
            zero_reg  <= d_tag[0];
        end
    end

    tppw_divider #(
        .NUM_W (NUM_W),
        .DEN_W (DEN_W),
        .TAG_W (2)
    ) u_divider (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (vld_reg[4]),
        .num       (num_reg),
        .den       (side5_reg.den),
        .tag_in    ({neg5_reg, side5_reg.zero}),
        .out_valid (d_valid),
        .quotient  (quotient),
        .tag_out   (d_tag)
    );

    // Restore the sign of the term
    assign q_signed = d_tag[1] ? -$signed({1'b0, quotient}) : $signed({1'b0, quotient});

    assign out_valid = pw_vld_reg;
    assign power     = power_reg;
    assign zero_out  = zero_reg;

endmodule

// ===== design/three_phase_line_real_power.sv =====
// Top level: three-phase line real power flow, one line per word.
// Depends on tppw_pkg, tppw_in_if, tppw_out_if and tppw_phase.
//
//   channel    | dir | word contents
//   -----------+-----+-----------------------------------------------------
//   line_in    | in  | R, X, sending/receiving voltages and angles, 3 phases
//   power_out  | out | line_power (Q34.6 W), zero_impedance, saturated
//
// A new word is taken every cycle while the pipeline is not held; each word passes
// through the CORDIC stages and the 84-stage bit-per-stage divider in each phase.
// rst_n clears all valid bits and the two-entry output queue at once.
// When the queue is full and the last stage holds a word, the whole pipeline
// holds; line_in.ready drops in that cycle and nothing is lost or repeated.
module three_phase_line_real_power #(
    parameter int CORDIC_STEPS = 16
) (
    input  logic      clk,
    input  logic      rst_n,
    tppw_in_if.sink   line_in,
    tppw_out_if.source power_out
);
    import tppw_pkg::*;

    localparam logic signed [SUM_W-1:0] SUM_MAX = SUM_W'(POW_MAX);
    localparam logic signed [SUM_W-1:0] SUM_MIN = SUM_W'(POW_MIN);

    logic                     en;
    logic                     push;
    logic                     pop;

    // Entry stage
    logic                     vld0_reg;
    logic [R_W-1:0]           r_reg;
    logic [R_W-1:0]           x_reg;
    logic [V_W-1:0]           vu_reg [0:2];
    logic [V_W-1:0]           vv_reg [0:2];
    logic signed [ANG_W-1:0]  ang_reg [0:2];
    logic [DEN_W-1:0]         den_reg;
    logic                     zero0_reg;
    logic [2*R_W-1:0]         rr_sq;
    logic [2*R_W-1:0]         xx_sq;
    logic [D_W-1:0]           d_next;
    phase_side_t              side [0:2];

    // Phase results
    logic                     ph_valid;
    logic                     ph_zero;
    logic signed [PW_W-1:0]   ph_power [0:2];

    // Sum and saturation stages
    logic                     vld1_reg;
    logic signed [SUM_W-1:0]  sum_reg;
    logic                     zero1_reg;
    result_t                  res_next;
    logic                     last_vld_reg;
    result_t                  last_res_reg;

    // Output queue
    result_t                  fifo_reg [0:1];
    logic                     wr_ptr_reg;
    logic                     rd_ptr_reg;
    logic [1:0]               cnt_reg;
    logic [1:0]               cnt_next;

    // Hold the pipeline only when the last word has nowhere to go
    assign en            = !(last_vld_reg && (cnt_reg == 2'd2));
    assign line_in.ready = en;
    assign push          = en && last_vld_reg;
    assign pop           = power_out.valid && power_out.ready;

    // Impedance magnitude squared, scaled by 2^10
    assign rr_sq  = line_in.resistance * line_in.resistance;
    assign xx_sq  = line_in.reactance * line_in.reactance;
    assign d_next = D_W'(rr_sq) + D_W'(xx_sq);

    always_comb
    begin
        for (int p = 0; p < 3; p++)
        begin
            side[p].r    = r_reg;
            side[p].x    = x_reg;
            side[p].vu   = vu_reg[p];
            side[p].vv   = vv_reg[p];
            side[p].den  = den_reg;
            side[p].zero = zero0_reg;
        end
    end

    // Advance valid bits of the top-level stages
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld0_reg     <= 1'b0;
            vld1_reg     <= 1'b0;
            last_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            vld0_reg     <= line_in.valid;
            vld1_reg     <= ph_valid;
            last_vld_reg <= vld1_reg;
        end
    end

    // Capture the word and advance sum and saturation data
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            r_reg        <= line_in.resistance;
            x_reg        <= line_in.reactance;
            vu_reg[0]    <= line_in.from_voltage_a;
            vu_reg[1]    <= line_in.from_voltage_b;
            vu_reg[2]    <= line_in.from_voltage_c;
            vv_reg[0]    <= line_in.to_voltage_a;
            vv_reg[1]    <= line_in.to_voltage_b;
            vv_reg[2]    <= line_in.to_voltage_c;
            ang_reg[0]   <= line_in.angle_diff_a;
            ang_reg[1]   <= line_in.angle_diff_b;
            ang_reg[2]   <= line_in.angle_diff_c;
            den_reg      <= {d_next, 10'd0};
            zero0_reg    <= (d_next == '0);
            sum_reg      <= SUM_W'(ph_power[0]) + SUM_W'(ph_power[1]) + SUM_W'(ph_power[2]);
            zero1_reg    <= ph_zero;
            last_res_reg <= res_next;
        end
    end

    tppw_phase #(.STEPS (CORDIC_STEPS)) u_phase_a (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (vld0_reg),
        .side_in   (side[0]),
        .ang       (ang_reg[0]),
        .out_valid (ph_valid),
        .power     (ph_power[0]),
        .zero_out  (ph_zero)
    );

    tppw_phase #(.STEPS (CORDIC_STEPS)) u_phase_b (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (vld0_reg),
        .side_in   (side[1]),
        .ang       (ang_reg[1]),
        .out_valid (),
        .power     (ph_power[1]),
        .zero_out  ()
    );

    tppw_phase #(.STEPS (CORDIC_STEPS)) u_phase_c (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (vld0_reg),
        .side_in   (side[2]),
        .ang       (ang_reg[2]),
        .out_valid (),
        .power     (ph_power[2]),
        .zero_out  ()
    );

    // Force zero on a shorted line, clip everything else to 40 bits
    always_comb
    begin
        res_next.zero_impedance = zero1_reg;
        res_next.saturated      = 1'b0;
        res_next.line_power     = POW_W'(sum_reg);
        if (zero1_reg)
        begin
            res_next.line_power = '0;
        end
        else if (sum_reg > SUM_MAX)
        begin
            res_next.line_power = POW_MAX;
            res_next.saturated  = 1'b1;
        end
        else if (sum_reg < SUM_MIN)
        begin
            res_next.line_power = POW_MIN;
            res_next.saturated  = 1'b1;
        end
    end

    // Output queue pointers and fill count
    always_comb
    begin
        cnt_next = cnt_reg;
        if (push && !pop)
        begin
            cnt_next = cnt_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            fifo_reg[wr_ptr_reg] <= last_res_reg;
        end
    end

    assign power_out.valid          = (cnt_reg != 2'd0);
    assign power_out.line_power     = fifo_reg[rd_ptr_reg].line_power;
    assign power_out.zero_impedance = fifo_reg[rd_ptr_reg].zero_impedance;
    assign power_out.saturated      = fifo_reg[rd_ptr_reg].saturated;

    // Checks
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= 2'd2)
        else $error("output queue count out of range");

    a_zero_out: assert property (@(posedge clk) disable iff (!rst_n)
        (power_out.valid && power_out.zero_impedance) |->
        (power_out.line_power == '0 && !power_out.saturated))
        else $error("zero impedance word carries power or clip flag");

    a_sat_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (power_out.valid && power_out.saturated) |->
        (power_out.line_power == POW_MAX || power_out.line_power == POW_MIN))
        else $error("clipped word not at a range bound");

    a_hold_last: assert property (@(posedge clk) disable iff (!rst_n)
        (last_vld_reg && !en) |=> (last_vld_reg && $stable(last_res_reg)))
        else $error("last stage word lost during hold");

endmodule
